FILE: design/etp_pkg.sv
package etp_pkg;

	// Width of a function id and of a stored total
	localparam int IdW    = 7;
	localparam int TotalW = 32;
	localparam int DepthW = 7;
	localparam int FcW    = 8;

	// Reset value of the function_count register
	localparam logic [FcW-1:0] FcReset = 8'd128;

	// Register indexes on the configuration port
	localparam logic RegFunctionCount = 1'b0;

	// Event outcome
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BAD_ID = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// Push or pop of the call stack for one committed event
	typedef struct packed {
		logic           push;
		logic           pop;
		logic [IdW-1:0] id;
	} stack_op_t;

	// Credit request toward the totals table
	typedef struct packed {
		logic              credit;
		logic [IdW-1:0]    id;
		logic [TotalW-1:0] amount;
	} credit_req_t;

	// One result item
	typedef struct packed {
		logic              credited_valid;
		logic [IdW-1:0]    credited_id;
		logic [TotalW-1:0] credited_total;
		logic [DepthW-1:0] stack_depth;
		status_t           status;
	} result_t;

endpackage

FILE: design/etp_stack.sv
module etp_stack #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  etp_pkg::stack_op_t            op,
	output logic [$clog2(STACK_DEPTH+1)-1:0] sp,
	output logic [etp_pkg::IdW-1:0]       tos
);

	localparam int SpW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(STACK_DEPTH);

	logic [etp_pkg::IdW-1:0] mem [STACK_DEPTH];
	logic [SpW-1:0]          sp_q;
	logic [SpW-1:0]          sp_next;
	logic [etp_pkg::IdW-1:0] tos_q;
	logic [etp_pkg::IdW-1:0] below_q;
	logic [AW-1:0]           rd_addr;
	logic [SpW-1:0]          sp_m2;

	// Next depth
	always_comb begin
		sp_next = sp_q;
		if (op.push) begin
			sp_next = sp_q + SpW'(1);
		end else if (op.pop) begin
			sp_next = sp_q - SpW'(1);
		end
	end

	// Keep the entry just below the next top ready for a pop
	assign sp_m2   = sp_next - SpW'(2);
	assign rd_addr = (sp_next >= SpW'(2)) ? sp_m2[AW-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else begin
			sp_q <= sp_next;
		end
	end

	// Store every pushed id; read the second entry from the top each cycle
	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[sp_q[AW-1:0]] <= op.id;
		end
		below_q <= mem[rd_addr];
	end

	// Top of stack in a register
	always_ff @(posedge clk) begin
		if (op.push) begin
			tos_q <= op.id;
		end else if (op.pop) begin
			tos_q <= below_q;
		end
	end

	assign sp  = sp_q;
	assign tos = tos_q;

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SpW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		op.pop |-> sp_q != '0)
		else $error("pop on empty stack");

	a_push_top: assert property (@(posedge clk) disable iff (!arst_n)
		op.push |=> tos_q == $past(op.id) && sp_q == $past(sp_q) + SpW'(1))
		else $error("push did not update top");

endmodule

FILE: design/etp_ctrl.sv
module etp_ctrl #(
	parameter int MAX_FUNCS   = 128,
	parameter int STACK_DEPTH = 64,
	parameter int TIME_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          commit,
	input  logic [etp_pkg::IdW-1:0]       func_id,
	input  logic                          is_start,
	input  logic [TIME_BITS-1:0]          timestamp,
	input  logic [etp_pkg::FcW-1:0]       function_count,
	output etp_pkg::credit_req_t          req,
	output etp_pkg::status_t              status,
	output logic [etp_pkg::DepthW-1:0]    depth
);

	localparam int SpW  = $clog2(STACK_DEPTH + 1);
	localparam int AmtW = TIME_BITS + 1;

	etp_pkg::stack_op_t      op;
	logic [SpW-1:0]          sp;
	logic [etp_pkg::IdW-1:0] tos;

	logic                    have_prev_q;
	logic                    prev_start_q;
	logic [etp_pkg::IdW-1:0] prev_id_q;
	logic [TIME_BITS-1:0]    last_time_q;

	logic                    ok;
	logic [TIME_BITS-1:0]    diff;
	logic [AmtW-1:0]         diff_x;
	logic [AmtW-1:0]         amount;
	logic [64:0]             amount_w;
	logic [SpW-1:0]          sp_after;

	etp_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (op),
		.sp    (sp),
		.tos   (tos)
	);

	// Check order: id range, then stack full or empty
	always_comb begin
		if (!(etp_pkg::FcW'(func_id) < function_count) ||
				!(32'(func_id) < 32'(MAX_FUNCS))) begin
			status = etp_pkg::ST_BAD_ID;
		end else if (is_start && sp >= SpW'(STACK_DEPTH)) begin
			status = etp_pkg::ST_FULL;
		end else if (!is_start && sp == '0) begin
			status = etp_pkg::ST_EMPTY;
		end else begin
			status = etp_pkg::ST_OK;
		end
	end

	assign ok = (status == etp_pkg::ST_OK);

	// Elapsed ticks, adjusted by the pair of event kinds
	assign diff   = (timestamp >= last_time_q) ? (timestamp - last_time_q) : '0;
	assign diff_x = {1'b0, diff};

	always_comb begin
		if (prev_start_q) begin
			amount = is_start ? diff_x : diff_x + AmtW'(1);
		end else if (is_start) begin
			amount = (diff_x == '0) ? '0 : diff_x - AmtW'(1);
		end else begin
			amount = diff_x;
		end
	end

	// Clamp the credit to the total width
	assign amount_w = 65'(amount);

	always_comb begin
		req.credit = ok && have_prev_q && (prev_start_q || sp != '0);
		req.id     = prev_start_q ? prev_id_q : tos;
		req.amount = (|amount_w[64:32]) ? '1 : amount_w[31:0];
	end

	// Stack update on a committed good event
	always_comb begin
		op.push = commit && ok && is_start;
		op.pop  = commit && ok && !is_start;
		op.id   = func_id;
	end

	always_comb begin
		sp_after = sp;
		if (ok) begin
			sp_after = is_start ? sp + SpW'(1) : sp - SpW'(1);
		end
	end

	assign depth = etp_pkg::DepthW'(sp_after);

	// Record the previous event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q  <= 1'b0;
			prev_start_q <= 1'b0;
			prev_id_q    <= '0;
			last_time_q  <= '0;
		end else if (commit && ok) begin
			have_prev_q  <= 1'b1;
			prev_start_q <= is_start;
			prev_id_q    <= func_id;
			last_time_q  <= timestamp;
		end
	end

endmodule

FILE: design/etp_acc.sv
module etp_acc #(
	parameter int MAX_FUNCS = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s2_adv,
	input  logic                       out_load,
	input  logic                       s1_valid,
	input  etp_pkg::credit_req_t       req,
	input  etp_pkg::status_t           status,
	input  logic [etp_pkg::DepthW-1:0] depth,
	output logic                       s2_valid,
	output etp_pkg::result_t           result
);

	localparam int TotDepth = (MAX_FUNCS < 128) ? MAX_FUNCS : 128;
	localparam int IdxW     = $clog2(TotDepth);

	logic [etp_pkg::TotalW-1:0] mem [TotDepth];
	logic [TotDepth-1:0]        vld_q;

	logic                       valid_s2;
	etp_pkg::credit_req_t       req_s2;
	etp_pkg::status_t           status_s2;
	logic [etp_pkg::DepthW-1:0] depth_s2;

	logic [etp_pkg::TotalW-1:0] rd_s2;
	logic                       rdv_s2;
	logic                       fwd_s2;
	logic [etp_pkg::TotalW-1:0] fwd_data_s2;

	logic [IdxW-1:0]            rd_addr;
	logic [IdxW-1:0]            wr_addr;
	logic                       wr_en;
	logic [etp_pkg::TotalW-1:0] cur;
	logic [etp_pkg::TotalW:0]   sum;
	logic [etp_pkg::TotalW-1:0] total;

	assign rd_addr = req.id[IdxW-1:0];
	assign wr_addr = req_s2.id[IdxW-1:0];
	assign wr_en   = valid_s2 && req_s2.credit && out_load;

	// Stage two control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_adv) begin
			valid_s2 <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			req_s2    <= req;
			status_s2 <= status;
			depth_s2  <= depth;
		end
	end

	// Read the total; forward a write landing on the same entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= total;
		end
		if (s2_adv) begin
			rd_s2       <= mem[rd_addr];
			rdv_s2      <= vld_q[rd_addr];
			fwd_s2      <= wr_en && (wr_addr == rd_addr);
			fwd_data_s2 <= total;
		end
	end

	// Entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Saturating add
	always_comb begin
		if (fwd_s2) begin
			cur = fwd_data_s2;
		end else if (rdv_s2) begin
			cur = rd_s2;
		end else begin
			cur = '0;
		end
		sum   = {1'b0, cur} + {1'b0, req_s2.amount};
		total = sum[etp_pkg::TotalW] ? '1 : sum[etp_pkg::TotalW-1:0];
	end

	always_comb begin
		result.credited_valid = req_s2.credit;
		result.credited_id    = req_s2.credit ? req_s2.id : '0;
		result.credited_total = req_s2.credit ? total : '0;
		result.stack_depth    = depth_s2;
		result.status         = status_s2;
	end

	assign s2_valid = valid_s2;

endmodule

FILE: design/exclusive_time_profiler.sv
// Exclusive-time profiler: one trace event in, one result out.
// A result passes through the input register, the total read register and the output
// register. Throughput: one event per cycle while the result side does not stall; the total
// read-modify-write forwards back to back.
// Reset: control state clears at once, function_count returns to 128; totals
// read as zero through per-entry valid bits, so there is no clearing pass.
module exclusive_time_profiler #(
	parameter int MAX_FUNCS   = 128,
	parameter int STACK_DEPTH = 64,
	parameter int TIME_BITS   = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [etp_pkg::IdW-1:0]    func_id,
	input  logic                       is_start,
	input  logic [TIME_BITS-1:0]       timestamp,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       credited_valid,
	output logic [etp_pkg::IdW-1:0]    credited_id,
	output logic [etp_pkg::TotalW-1:0] credited_total,
	output logic [etp_pkg::DepthW-1:0] stack_depth,
	output logic [1:0]                 status
);

	logic [etp_pkg::FcW-1:0]    function_count_q;

	logic                       valid_s1;
	logic [etp_pkg::IdW-1:0]    id_s1;
	logic                       start_s1;
	logic [TIME_BITS-1:0]       time_s1;

	logic                       out_valid_q;
	etp_pkg::result_t           result_q;

	logic                       out_load;
	logic                       s2_adv;
	logic                       s1_adv;
	logic                       s2_valid;
	etp_pkg::credit_req_t       req;
	etp_pkg::status_t           ev_status;
	logic [etp_pkg::DepthW-1:0] depth;
	etp_pkg::result_t           result;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			function_count_q <= etp_pkg::FcReset;
		end else if (psel && penable && pwrite && paddr[2] == etp_pkg::RegFunctionCount) begin
			function_count_q <= pwdata[etp_pkg::FcW-1:0];
		end
	end

	assign prdata = (paddr[2] == etp_pkg::RegFunctionCount) ?
		32'(function_count_q) : '0;

	// Pipeline advance: each stage moves when the next one frees up
	assign out_load = !out_valid_q || !out_stall;
	assign s2_adv   = !s2_valid || out_load;
	assign s1_adv   = !valid_s1 || s2_adv;
	assign in_stall = !s1_adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && in_valid) begin
			id_s1    <= func_id;
			start_s1 <= is_start;
			time_s1  <= timestamp;
		end
	end

	etp_ctrl #(
		.MAX_FUNCS  (MAX_FUNCS),
		.STACK_DEPTH(STACK_DEPTH),
		.TIME_BITS  (TIME_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.commit        (valid_s1 && s2_adv),
		.func_id       (id_s1),
		.is_start      (start_s1),
		.timestamp     (time_s1),
		.function_count(function_count_q),
		.req           (req),
		.status        (ev_status),
		.depth         (depth)
	);

	etp_acc #(
		.MAX_FUNCS(MAX_FUNCS)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.s2_adv  (s2_adv),
		.out_load(out_load),
		.s1_valid(valid_s1),
		.req     (req),
		.status  (ev_status),
		.depth   (depth),
		.s2_valid(s2_valid),
		.result  (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign credited_valid = result_q.credited_valid;
	assign credited_id    = result_q.credited_id;
	assign credited_total = result_q.credited_total;
	assign stack_depth    = result_q.stack_depth;
	assign status         = result_q.status;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q && out_stall && s2_valid && valid_s1)
		else $error("input stalled with room in the pipeline");

	a_reject_no_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.status != etp_pkg::ST_OK |-> !result_q.credited_valid)
		else $error("rejected request credited time");

	a_no_credit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.credited_valid |->
			result_q.credited_id == '0 && result_q.credited_total == '0)
		else $error("uncredited result carries a total");

endmodule

FILE: tb/sv/etp_checker.sv
module etp_checker
	import etp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [IdW-1:0]    func_id,
	input  logic              is_start,
	input  logic [31:0]       timestamp,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              credited_valid,
	input  logic [IdW-1:0]    credited_id,
	input  logic [TotalW-1:0] credited_total,
	input  logic [DepthW-1:0] stack_depth,
	input  logic [1:0]        status,
	output int                mismatches,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StackSlots = 64;
	localparam int TableSize  = 128;
	localparam logic [63:0] TotalMax = 64'h0000_0000_FFFF_FFFF;
	localparam logic [2:0] AddrFunctionCount = {RegFunctionCount, 2'b00};

	// Shadow profiler state
	logic [IdW-1:0]    frames [StackSlots];
	int unsigned       depth;
	logic              seen_event;
	logic              last_was_start;
	logic [IdW-1:0]    last_id;
	logic [31:0]       last_stamp;
	logic [TotalW-1:0] exclusive_total [TableSize];
	logic [FcW-1:0]    id_limit;
	result_t           pending_results [$];
	int                errors;

	// Apply one trace event to the shadow state and build its result
	function automatic result_t profile_event(logic [IdW-1:0] id, logic st, logic [31:0] t);
		result_t        r;
		logic [63:0]    elapsed;
		logic [63:0]    amount;
		logic [63:0]    sum;
		logic [IdW-1:0] target;
		logic           credit;
		r = '0;
		r.status = ST_OK;
		if (id >= id_limit)
			r.status = ST_BAD_ID;
		else if (st && depth >= StackSlots)
			r.status = ST_FULL;
		else if (!st && depth == 0)
			r.status = ST_EMPTY;
		if (r.status == ST_OK) begin
			// backward time counts as no elapsed time
			elapsed = (t >= last_stamp) ? 64'(t - last_stamp) : 64'd0;
			credit = 1'b0;
			target = '0;
			amount = '0;
			if (seen_event) begin
				if (last_was_start) begin
					credit = 1'b1;
					target = last_id;
					amount = st ? elapsed : elapsed + 64'd1;
				end else if (depth != 0) begin
					credit = 1'b1;
					target = frames[depth-1];
					amount = st ? ((elapsed == 0) ? 64'd0 : elapsed - 64'd1) : elapsed;
				end
			end
			// saturating update of the credited total
			if (credit) begin
				sum = 64'(exclusive_total[target]) + amount;
				if (sum > TotalMax)
					sum = TotalMax;
				exclusive_total[target] = sum[TotalW-1:0];
				r.credited_valid = 1'b1;
				r.credited_id = target;
				r.credited_total = sum[TotalW-1:0];
			end
			if (st) begin
				frames[depth] = id;
				depth++;
			end else begin
				depth--;
			end
			seen_event = 1'b1;
			last_was_start = st;
			last_id = id;
			last_stamp = t;
		end
		r.stack_depth = depth[DepthW-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (act !== exp) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
			errors++;
		end
	endtask

	// Track config writes, predict on accepted requests, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			depth = 0;
			seen_event = 1'b0;
			last_was_start = 1'b0;
			last_id = '0;
			last_stamp = '0;
			id_limit = FcReset;
			for (int i = 0; i < TableSize; i++)
				exclusive_total[i] = '0;
			pending_results.delete();
			errors = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == AddrFunctionCount)
				id_limit = pwdata[FcW-1:0];
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual id %0d total %0d",
						$time, credited_id, credited_total);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("credited_valid", 32'(want.credited_valid), 32'(credited_valid));
					check_field("credited_id", 32'(want.credited_id), 32'(credited_id));
					check_field("credited_total", want.credited_total, credited_total);
					check_field("stack_depth", 32'(want.stack_depth), 32'(stack_depth));
					check_field("status", 32'(want.status), 32'(status));
				end
			end
			if (in_valid && !in_stall)
				pending_results.push_back(profile_event(func_id, is_start, timestamp));
			mismatches <= errors;
			outstanding <= pending_results.size();
		end
	end

endmodule

FILE: tb/sv/tb_exclusive_time_profiler.sv
module tb_exclusive_time_profiler;
	import etp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 1000;
	localparam int FillLength    = 72;
	localparam logic [2:0] AddrFunctionCount = {RegFunctionCount, 2'b00};

	typedef enum int {MIX, DEEP, SHALLOW, NOISE, FILL} trace_mode_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [IdW-1:0]    func_id;
	logic              is_start;
	logic [31:0]       timestamp;
	logic              out_valid;
	logic              out_stall;
	logic              credited_valid;
	logic [IdW-1:0]    credited_id;
	logic [TotalW-1:0] credited_total;
	logic [DepthW-1:0] stack_depth;
	logic [1:0]        status;
	int                mismatches;
	int                outstanding;

	// Stimulus-side view of the call stack, to keep traces well formed
	logic [IdW-1:0] gen_frames [$];
	logic [FcW-1:0] gen_limit;
	logic [31:0]    stamp;
	int             idle_level;
	int             stall_left;
	int             quiet_cycles;

	exclusive_time_profiler dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.func_id(func_id), .is_start(is_start), .timestamp(timestamp),
		.out_valid(out_valid), .out_stall(out_stall),
		.credited_valid(credited_valid), .credited_id(credited_id),
		.credited_total(credited_total), .stack_depth(stack_depth), .status(status)
	);

	etp_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.func_id(func_id), .is_start(is_start), .timestamp(timestamp),
		.out_valid(out_valid), .out_stall(out_stall),
		.credited_valid(credited_valid), .credited_id(credited_id),
		.credited_total(credited_total), .stack_depth(stack_depth), .status(status),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side in random bursts
	always @(posedge clk) begin
		if (!arst_n || idle_level == 0) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, (idle_level == 1) ? 7 : 2) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogLimit) begin
			$display("** exclusive_time_profiler: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Wait until every expected result has been taken
	task automatic wait_idle();
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// Drop the request line and drain before touching the register
	task automatic set_limit(logic [FcW-1:0] limit);
		in_valid <= 1'b0;
		wait_idle();
		write_reg(AddrFunctionCount, 32'(limit));
		gen_limit = limit;
	endtask

	// Present one request, with an optional gap before it, and hold until taken
	task automatic post_event(logic [IdW-1:0] id, logic st, logic [31:0] t);
		int gap;
		if (idle_level != 0 && $urandom_range(0, (idle_level == 1) ? 5 : 1) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 7);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func_id <= id;
		is_start <= st;
		timestamp <= t;
		stamp = t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (id < gen_limit) begin
			if (st && gen_frames.size() < 64)
				gen_frames.push_back(id);
			else if (!st && gen_frames.size() != 0)
				void'(gen_frames.pop_back());
		end
	endtask

	task automatic gen_event(trace_mode_t mode);
		int             span;
		logic [IdW-1:0] id;
		logic           st;
		logic [31:0]    t;
		span = (gen_limit > 128) ? 128 : int'(gen_limit);
		case (mode)
			FILL:    st = 1'b1;
			DEEP:    st = ($urandom_range(0, 9) < 8);
			SHALLOW: st = ($urandom_range(0, 9) < 3);
			default: st = 1'($urandom_range(0, 1));
		endcase
		// ends mostly close the top frame; a few ids are out of range or mismatched
		if (span == 0 || $urandom_range(0, 19) == 0 || (mode == NOISE && $urandom_range(0, 2) == 0))
			id = IdW'($urandom_range(0, 127));
		else if (!st && gen_frames.size() != 0 && $urandom_range(0, 9) != 0)
			id = gen_frames[$];
		else
			id = IdW'($urandom_range(0, span - 1));
		// mostly small forward steps, sometimes large jumps or steps back
		case ($urandom_range(0, 19))
			0:       t = $urandom();
			1:       t = stamp - $urandom_range(1, 50);
			2, 3:    t = stamp + $urandom_range(0, 100000);
			default: t = stamp + $urandom_range(0, 3);
		endcase
		post_event(id, st, t);
	endtask

	task automatic run_phase(int items, bit with_fill);
		int          left;
		int          chunk;
		trace_mode_t mode;
		left = items;
		while (left > 0) begin
			if (with_fill && left == items) begin
				mode = FILL;
				chunk = FillLength;
			end else begin
				mode = trace_mode_t'($urandom_range(0, 4));
				chunk = (mode == FILL) ? FillLength : $urandom_range(20, 120);
			end
			if (chunk > left)
				chunk = left;
			if (idle_level != 0)
				idle_level = $urandom_range(1, 2);
			repeat (chunk) gen_event(mode);
			left -= chunk;
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func_id = '0;
		is_start = 1'b0;
		timestamp = '0;
		out_stall = 1'b0;
		stall_left = 0;
		quiet_cycles = 0;
		idle_level = 1;
		gen_limit = FcReset;
		stamp = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed trace: empty stack, bad ids, every kind pair, backward time
		set_limit(8'd100);
		post_event(7'd5, 1'b0, 32'd3);
		post_event(7'd120, 1'b1, 32'd4);
		post_event(7'd0, 1'b1, 32'd10);
		post_event(7'd99, 1'b1, 32'd10);
		post_event(7'd99, 1'b0, 32'd10);
		post_event(7'd7, 1'b1, 32'd10);
		post_event(7'd3, 1'b0, 32'd15);
		post_event(7'd8, 1'b1, 32'd12);
		post_event(7'd8, 1'b0, 32'd20);
		post_event(7'd0, 1'b0, 32'd25);
		post_event(7'd2, 1'b1, 32'd30);
		post_event(7'd2, 1'b0, 32'hFFFF_FFFF);
		post_event(7'd2, 1'b1, 32'hFFFF_FFFF);
		post_event(7'd3, 1'b1, 32'hFFFF_FFFF);
		post_event(7'd3, 1'b0, 32'hFFFF_FFFF);
		post_event(7'd2, 1'b0, 32'hFFFF_FFFF);
		post_event(7'd127, 1'b1, 32'd0);
		post_event(7'd100, 1'b0, 32'd0);
		post_event(7'd1, 1'b1, 32'd0);
		post_event(7'd1, 1'b0, 32'd1);

		// Random traces over several id limits
		set_limit(8'd128);
		run_phase(750, 1'b1);
		set_limit(8'd1);
		run_phase(200, 1'b0);
		set_limit(8'd0);
		run_phase(30, 1'b0);
		set_limit(8'd255);
		run_phase(400, 1'b1);
		set_limit(8'($urandom_range(2, 127)));
		run_phase(300, 1'b0);

		// Last stretch without idling on either side
		idle_level = 0;
		set_limit(8'd64);
		run_phase(250, 1'b0);
		in_valid <= 1'b0;

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** exclusive_time_profiler: PASSED **");
		else
			$display("** exclusive_time_profiler: FAILED **");
		$finish;
	end

endmodule

FILE: exclusive_time_profiler.f
design/etp_pkg.sv
design/etp_stack.sv
design/etp_ctrl.sv
design/etp_acc.sv
design/exclusive_time_profiler.sv
tb/sv/etp_checker.sv
tb/sv/tb_exclusive_time_profiler.sv
